// ===== rtl/signed_int_to_decimal_ascii_assert.svh =====
// Assertion macros shared by the signed integer to decimal ASCII RTL.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SIDTA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define SIDTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/sidta_pkg.sv =====
// Shared constants for the signed integer to decimal ASCII converter.
package sidta_pkg;

    localparam int NUMBER_W            = 64;
    localparam int CHAR_W              = 6;
    localparam int DIGIT_W             = 4;
    localparam int DEFAULT_VALUE_WIDTH = 64;

    localparam logic [CHAR_W-1:0]  DIGIT_BASE     = 6'd48;
    localparam logic [CHAR_W-1:0]  MINUS_CHAR     = 6'd45;
    localparam logic [CHAR_W-1:0]  NINE_CHAR      = 6'd57;
    localparam logic [DIGIT_W-1:0] BCD_ADJUST_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJUST     = 4'd3;
    localparam logic [DIGIT_W-1:0] BCD_MAX        = 4'd9;

endpackage

// ===== rtl/sidta_dabble_step.sv =====
// One shift-add-3 step: adjust every BCD digit, then shift one binary bit in.
module sidta_dabble_step #(
    parameter int VALUE_WIDTH = 64,
    parameter int NUM_DIGITS  = 19
) (
    input  logic [NUM_DIGITS-1:0][sidta_pkg::DIGIT_W-1:0] bcd_in,
    input  logic [VALUE_WIDTH-1:0]                        bin_in,
    output logic [NUM_DIGITS-1:0][sidta_pkg::DIGIT_W-1:0] bcd_out,
    output logic [VALUE_WIDTH-1:0]                        bin_out
);
    import sidta_pkg::*;

    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] adjusted;
    logic [NUM_DIGITS*DIGIT_W-1:0]      adjusted_flat;

    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (bcd_in[i] >= BCD_ADJUST_MIN) begin
                adjusted[i] = bcd_in[i] + BCD_ADJUST;
            end else begin
                adjusted[i] = bcd_in[i];
            end
        end
    end

    assign adjusted_flat = adjusted;
    // The top digit's carry out is never set: enough digits are sized in.
    assign bcd_out = {adjusted_flat[NUM_DIGITS*DIGIT_W-2:0], bin_in[VALUE_WIDTH-1]};
    assign bin_out = {bin_in[VALUE_WIDTH-2:0], 1'b0};

endmodule

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Top level: signed integer to decimal ASCII character stream.
//
// Converts the low VALUE_WIDTH bits of s_number, read as two's complement, into
// decimal text sent one character per request on the m_ channel, most
// significant first, with a leading '-' for negative values, no leading zeros,
// and m_last high on the final digit. A request is taken in ST_IDLE, then a
// shared shift-add-3 unit runs in ST_CONVERT over all VALUE_WIDTH bits, one
// input bit per cycle; after that the sequencer sends the sign when negative
// and walks the NUM_DIGITS BCD positions one per cycle, skipping leading zeros
// and holding a character while the output register is still full. s_ready
// returns once the final character sits in the output register, so the next
// conversion overlaps delivery of that character.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = sidta_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sidta_pkg::NUMBER_W-1:0] s_number,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sidta_pkg::CHAR_W-1:0]        m_ascii_char,
    output logic                                m_last
);
    import sidta_pkg::*;

    `include "signed_int_to_decimal_ascii_assert.svh"

    // Digits for the largest magnitude 2^(VALUE_WIDTH-1).
    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
    localparam int CNT_W      = $clog2(VALUE_WIDTH);
    localparam int PTR_W      = $clog2(NUM_DIGITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t                             state_reg, state_next;
    logic [VALUE_WIDTH-1:0]             bin_reg, bin_next;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_reg, bcd_next;
    logic [CNT_W-1:0]                   count_reg, count_next;
    logic [PTR_W-1:0]                   ptr_reg, ptr_next;
    logic                               neg_reg, neg_next;
    logic                               started_reg, started_next;
    logic                               m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]                  m_char_reg, m_char_next;
    logic                               m_last_reg, m_last_next;

    logic [VALUE_WIDTH-1:0]             raw;
    logic [VALUE_WIDTH-1:0]             magnitude;
    logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_stepped;
    logic [VALUE_WIDTH-1:0]             bin_stepped;
    logic [DIGIT_W-1:0]                 cur_digit;
    logic                               at_last_digit;
    logic                               out_free;

    sidta_dabble_step #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_step (
        .bcd_in  (bcd_reg),
        .bin_in  (bin_reg),
        .bcd_out (bcd_stepped),
        .bin_out (bin_stepped)
    );

    assign raw           = s_number[VALUE_WIDTH-1:0];
    assign magnitude     = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
    assign cur_digit     = bcd_reg[ptr_reg];
    assign at_last_digit = (ptr_reg == '0);
    assign out_free      = !m_valid_reg || m_ready;

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_ascii_char = m_char_reg;
    assign m_last       = m_last_reg;

    always_comb begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        neg_next     = neg_reg;
        started_next = started_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;

        // Drop the held character once it is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    bin_next   = magnitude;
                    bcd_next   = '0;
                    count_next = '0;
                    neg_next   = raw[VALUE_WIDTH-1];
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                bin_next   = bin_stepped;
                bcd_next   = bcd_stepped;
                count_next = count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(VALUE_WIDTH - 1)) begin
                    ptr_next     = PTR_W'(NUM_DIGITS - 1);
                    started_next = 1'b0;
                    state_next   = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = MINUS_CHAR;
                    m_last_next  = 1'b0;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (cur_digit == '0 && !started_reg && !at_last_digit) begin
                    // Skip a leading zero without producing a character.
                    ptr_next = ptr_reg - PTR_W'(1);
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = DIGIT_BASE + CHAR_W'(cur_digit);
                    m_last_next  = at_last_digit;
                    started_next = 1'b1;
                    if (at_last_digit) begin
                        state_next = ST_IDLE;
                    end else begin
                        ptr_next = ptr_reg - PTR_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        bin_reg     <= bin_next;
        bcd_reg     <= bcd_next;
        count_reg   <= count_next;
        ptr_reg     <= ptr_next;
        neg_reg     <= neg_next;
        started_reg <= started_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    `SIDTA_ASSERT_NOW(a_char_range, aclk, aresetn, m_valid_reg,
        (m_char_reg == MINUS_CHAR) || ((m_char_reg >= DIGIT_BASE) && (m_char_reg <= NINE_CHAR)))
    `SIDTA_ASSERT_NOW(a_sign_not_last, aclk, aresetn,
        m_valid_reg && (m_char_reg == MINUS_CHAR), !m_last_reg)
    `SIDTA_ASSERT_NOW(a_bcd_digit_valid, aclk, aresetn, state_reg == ST_EMIT,
        cur_digit <= BCD_MAX)
    `SIDTA_ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_valid && s_ready,
        (state_reg == ST_CONVERT) && (count_reg == '0))

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Testbench for signed_int_to_decimal_ascii: directed and random numbers, each character checked.
module tb;
    import sidta_pkg::*;

    localparam int HALF_PERIOD      = 5;
    localparam int RESET_CYCLES     = 12;
    localparam int RANDOM_PER_PHASE = 54;
    localparam int SETTLE_CYCLES    = 100;
    localparam int STALL_LIMIT      = 2000;
    localparam int MAX_CHARS        = 20;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii_char;
        logic              last;
    } text_char_t;

    typedef struct {
        logic [NUMBER_W-1:0] number;
        string               text;
    } number_row_t;

    logic                       aclk     = 1'b0;
    logic                       aresetn  = 1'b0;
    logic                       s_valid  = 1'b0;
    logic                       s_ready;
    logic signed [NUMBER_W-1:0] s_number = '0;
    logic                       m_valid;
    logic                       m_ready  = 1'b0;
    logic [CHAR_W-1:0]          m_ascii_char;
    logic                       m_last;

    text_char_t  text_q[$];
    number_row_t number_rows[$];
    string       cur_text    = "";
    int          errors      = 0;
    int          idle_cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;

    signed_int_to_decimal_ascii dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_number     (s_number),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ascii_char (m_ascii_char),
        .m_last       (m_last)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Decimal text of a 64-bit two's complement value, most significant first.
    function automatic void queue_decimal_text(input logic [NUMBER_W-1:0] raw);
        logic [NUMBER_W-1:0] mag;
        logic [DIGIT_W-1:0]  digit [MAX_CHARS];
        int                  ndig;
        ndig = 0;
        mag  = raw[NUMBER_W-1] ? (~raw + 1'b1) : raw;
        do begin
            digit[ndig] = DIGIT_W'(mag % 64'd10);
            mag         = mag / 64'd10;
            ndig++;
        end while (mag != 0 && ndig < MAX_CHARS);
        if (raw[NUMBER_W-1])
            text_q.push_back(text_char_t'{MINUS_CHAR, 1'b0});
        for (int k = ndig - 1; k >= 0; k--)
            text_q.push_back(text_char_t'{DIGIT_BASE + CHAR_W'(digit[k]), k == 0});
    endfunction

    function automatic void queue_typed_text(input string text);
        byte c;
        for (int i = 0; i < text.len(); i++) begin
            c = text[i];
            text_q.push_back(text_char_t'{c[CHAR_W-1:0], i == text.len() - 1});
        end
    endfunction

    function automatic logic [NUMBER_W-1:0] pick_number();
        logic [NUMBER_W-1:0] value;
        logic [NUMBER_W-1:0] scale;
        int                  ndig;
        scale = 1;
        ndig  = $urandom_range(1, 19);
        for (int i = 0; i < ndig; i++)
            scale = scale * 10;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: value = {$urandom, $urandom};
            4, 5, 6:    value = {$urandom, $urandom} % scale;
            7:          value = scale + NUMBER_W'($urandom_range(0, 2)) - 1;
            8:          value = {1'b1, {(NUMBER_W-1){1'b0}}} + NUMBER_W'($urandom_range(0, 3));
            default:    value = NUMBER_W'($urandom_range(0, 20));
        endcase
        if ($urandom_range(0, 1))
            value = ~value + 1'b1;
        return value;
    endfunction

    task automatic add_row(input logic [NUMBER_W-1:0] number, input string text);
        number_rows.push_back('{number, text});
    endtask

    task automatic send_number(input logic [NUMBER_W-1:0] value, input string text);
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        cur_text = text;
        s_valid  <= 1'b1;
        s_number <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Hold off the sender until every character owed has come out.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (text_q.size() == 0);
    endtask

    task automatic run_random_phase(input int tx_pct, input int rx_pct);
        drain_results();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (RANDOM_PER_PHASE) send_number(pick_number(), "");
    endtask

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (text_q.size() == 0) begin
                    errors++;
                    $display("%0t: char with nothing expected: actual char %0d last %0b",
                             $time, m_ascii_char, m_last);
                end else begin
                    want = text_q.pop_front();
                    if (m_ascii_char !== want.ascii_char) begin
                        errors++;
                        $display("%0t: ascii_char mismatch: expected %0d actual %0d",
                                 $time, want.ascii_char, m_ascii_char);
                    end
                    if (m_last !== want.last) begin
                        errors++;
                        $display("%0t: last mismatch: expected %0b actual %0b",
                                 $time, want.last, m_last);
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (cur_text.len() > 0)
                    queue_typed_text(cur_text);
                else
                    queue_decimal_text(s_number);
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        // Extremes, digit-count boundaries and zero, with the text written out.
        add_row(64'd0,                     "0");
        add_row(64'd1,                     "1");
        add_row(-64'sd1,                   "-1");
        add_row(64'd9,                     "9");
        add_row(64'd10,                    "10");
        add_row(-64'sd10,                  "-10");
        add_row(-64'sd99,                  "-99");
        add_row(64'h7FFF_FFFF_FFFF_FFFF,   "9223372036854775807");
        add_row(64'h8000_0000_0000_0000,   "-9223372036854775808");
        add_row(64'h8000_0000_0000_0001,   "-9223372036854775807");
        add_row(64'd1000000000000000000,   "1000000000000000000");
        add_row(64'd999999999999999999,    "999999999999999999");
        // Bit patterns, left to the predictor.
        add_row(64'h5555_5555_5555_5555,   "");
        add_row(64'hAAAA_AAAA_AAAA_AAAA,   "");
        add_row(64'h0123_4567_89AB_CDEF,   "");
        add_row(64'hFFFF_FFFF_0000_0000,   "");
        add_row(64'h0000_0000_FFFF_FFFF,   "");
        add_row(-64'sd12345678901234567,   "");

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 36;
        rx_idle_pct = 60;
        foreach (number_rows[i])
            send_number(number_rows[i].number, number_rows[i].text);

        run_random_phase(36, 60);
        run_random_phase(60, 36);
        run_random_phase(0, 0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
